[rtl/pfla_pkg.sv]
`default_nettype none

package pfla_pkg;

	localparam int NUM_PAGES_DEFAULT = 1024;

	localparam int PAGE_W   = 10;
	localparam int REGION_W = 11;
	localparam int TOTAL_W  = 11;
	localparam int CNT_W    = 2;
	localparam int INDEX_W  = 3;

	localparam logic [TOTAL_W-1:0] TOTAL_CAP = 11'd1024;

	typedef enum logic [1:0] {
		CMD_BUILD = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2
	} cmd_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_REGION_COUNT = 3'd0,
		REG_R0_FIRST     = 3'd1,
		REG_R0_LIMIT     = 3'd2,
		REG_R1_FIRST     = 3'd3,
		REG_R1_LIMIT     = 3'd4,
		REG_R2_FIRST     = 3'd5,
		REG_R2_LIMIT     = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_ALLOC  = 4'b0010,
		S_REGION = 4'b0100,
		S_LINK   = 4'b1000
	} state_t;

endpackage

`default_nettype wire

[rtl/page_free_list_allocator.sv]
// Free, unknown and empty-list allocate: done in the cycle after start, one per cycle.
// Other allocates: link-memory read on start, then head update in S_ALLOC; done registered.
// Build: S_REGION walks the regions, skipping empty ones; S_LINK links one page per cycle.
// busy stays high until the sequencer is idle again; done is a one-cycle strobe, no stall.
// Reset clears the head, the total and the region registers and sets the empty flag;
// the link memory is not cleared and holds garbage until a build or free writes it.
`default_nettype none

module page_free_list_allocator
	import pfla_pkg::*;
#(
	parameter int NUM_PAGES = NUM_PAGES_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          cmd,
	input  wire logic [PAGE_W-1:0]   page_in,
	output logic                     done,
	output logic                     status,
	output logic      [PAGE_W-1:0]   page_out,
	output logic      [TOTAL_W-1:0]  total_pages,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [INDEX_W-1:0]  cfg_index,
	input  wire logic [REGION_W-1:0] cfg_data
);

	localparam int PW = $clog2(NUM_PAGES);
	localparam int LW = $clog2(NUM_PAGES + 1);
	localparam int CW = ((LW > REGION_W) ? LW : REGION_W) + 1;
	localparam int SW = CW + 1;

	localparam logic [LW-1:0] END_MARK  = LW'(NUM_PAGES);
	localparam logic [CW-1:0] PAGES_CMP = CW'(NUM_PAGES);

	state_t               state_q;
	logic [CNT_W-1:0]     region_count_q;
	logic [REGION_W-1:0]  region_first_q [3];
	logic [REGION_W-1:0]  region_limit_q [3];
	logic [PW-1:0]        head_q;
	logic                 empty_q;
	logic [TOTAL_W-1:0]   tot_q;
	logic [CNT_W-1:0]     r_q;
	logic [PW-1:0]        p_q;
	logic [CW-1:0]        first_q;
	logic [CW-1:0]        lim_q;

	logic                 accept;
	cmd_t                 cmd_c;
	logic                 page_ok;
	logic                 done_d;
	logic [REGION_W-1:0]  sel_first;
	logic [REGION_W-1:0]  sel_limit;
	logic [CW-1:0]        lim_clip;
	logic [CW-1:0]        first_ext;
	logic [PW:0]          p_inc;
	logic                 last_page;
	logic [LW-1:0]        link_d;
	logic [SW-1:0]        sum;
	logic [TOTAL_W-1:0]   tot_sat;

	logic                 ram_we;
	logic [PW-1:0]        ram_waddr;
	logic [LW-1:0]        ram_wdata;
	logic                 ram_re;
	logic [LW-1:0]        ram_rdata;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cmd_c     = cmd_t'(cmd);
	assign cfg_ready = 1'b1;
	assign page_ok   = CW'(page_in) < PAGES_CMP;

	// finish now unless a build starts or an allocate has to read the link memory; also at the end of S_ALLOC or a build
	assign done_d = (accept && (cmd_c != CMD_BUILD) && !((cmd_c == CMD_ALLOC) && !empty_q))
		|| (state_q == S_ALLOC)
		|| ((state_q == S_REGION) && (r_q >= region_count_q));

	// region select for the walk
	always_comb begin
		unique case (r_q)
			2'd0: begin
				sel_first = region_first_q[0];
				sel_limit = region_limit_q[0];
			end
			2'd1: begin
				sel_first = region_first_q[1];
				sel_limit = region_limit_q[1];
			end
			2'd2: begin
				sel_first = region_first_q[2];
				sel_limit = region_limit_q[2];
			end
			default: begin
				sel_first = '0;
				sel_limit = '0;
			end
		endcase
	end

	assign first_ext = CW'(sel_first);
	assign lim_clip  = (CW'(sel_limit) > PAGES_CMP) ? PAGES_CMP : CW'(sel_limit);

	// chain walk: link to the next page, or the last page to the old head (end mark if empty)
	assign p_inc     = {1'b0, p_q} + (PW+1)'(1);
	assign last_page = (CW'(p_inc) == lim_q);
	always_comb begin
		if (!last_page) begin
			link_d = LW'(p_inc);
		end else if (empty_q) begin
			link_d = END_MARK;
		end else begin
			link_d = LW'(head_q);
		end
	end

	assign sum     = SW'(tot_q) + SW'(lim_q - first_q);
	assign tot_sat = (sum > SW'(TOTAL_CAP)) ? TOTAL_CAP : TOTAL_W'(sum);

	// link memory access
	always_comb begin
		ram_re = accept && (cmd_c == CMD_ALLOC) && !empty_q;
		if (state_q == S_LINK) begin
			ram_we    = 1'b1;
			ram_waddr = p_q;
			ram_wdata = link_d;
		end else begin
			ram_we    = accept && (cmd_c == CMD_FREE) && page_ok;
			ram_waddr = PW'(page_in);
			ram_wdata = empty_q ? END_MARK : LW'(head_q);
		end
	end

	pfla_link_ram #(
		.DEPTH (NUM_PAGES),
		.AW    (PW),
		.DW    (LW)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= '0;
			for (int i = 0; i < 3; i++) begin
				region_first_q[i] <= '0;
				region_limit_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REGION_COUNT: region_count_q    <= cfg_data[CNT_W-1:0];
				REG_R0_FIRST:     region_first_q[0] <= cfg_data;
				REG_R0_LIMIT:     region_limit_q[0] <= cfg_data;
				REG_R1_FIRST:     region_first_q[1] <= cfg_data;
				REG_R1_LIMIT:     region_limit_q[1] <= cfg_data;
				REG_R2_FIRST:     region_first_q[2] <= cfg_data;
				REG_R2_LIMIT:     region_limit_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			empty_q     <= 1'b1;
			tot_q       <= '0;
			r_q         <= '0;
			p_q         <= '0;
			first_q     <= '0;
			lim_q       <= '0;
			done        <= 1'b0;
			status      <= 1'b0;
			page_out    <= '0;
			total_pages <= '0;
		end else begin
			done <= done_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status      <= (cmd_c == CMD_ALLOC) && empty_q;
						page_out    <= '0;
						total_pages <= '0;
						unique case (cmd_c)
							CMD_BUILD: begin
								head_q  <= '0;
								empty_q <= 1'b1;
								tot_q   <= '0;
								r_q     <= '0;
								state_q <= S_REGION;
							end
							CMD_ALLOC: begin
								if (!empty_q) begin
									state_q <= S_ALLOC;
								end
							end
							CMD_FREE: begin
								if (page_ok) begin
									head_q  <= PW'(page_in);
									empty_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_ALLOC: begin
					page_out <= PAGE_W'(head_q);
					if (ram_rdata >= END_MARK) begin
						head_q  <= '0;
						empty_q <= 1'b1;
					end else begin
						head_q <= PW'(ram_rdata);
					end
					state_q <= S_IDLE;
				end
				S_REGION: begin
					if (r_q >= region_count_q) begin
						total_pages <= tot_q;
						state_q     <= S_IDLE;
					end else if (lim_clip <= first_ext) begin
						// skip an empty region
						r_q <= r_q + CNT_W'(1);
					end else begin
						first_q <= first_ext;
						lim_q   <= lim_clip;
						p_q     <= PW'(sel_first);
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (last_page) begin
						head_q  <= PW'(first_q);
						empty_q <= 1'b0;
						tot_q   <= tot_sat;
						r_q     <= r_q + CNT_W'(1);
						state_q <= S_REGION;
					end else begin
						p_q <= PW'(p_inc);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/pfla_link_ram.sv]
`default_nettype none

module pfla_link_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
